[rtl/cfbd_pkg.sv]
`default_nettype none
package cfbd_pkg;

   localparam int CFBD_BLOCK_BYTES = 16;
   localparam int KEY_BYTES = 256 / 8;
   localparam int KEY_BITS = 256;
   localparam int ROUNDS = 14;
   localparam int CSR_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 3;

   // request selector codes
   localparam logic [1:0] FUNC_INIT   = 2'd0;
   localparam logic [1:0] FUNC_CIPHER = 2'd1;
   localparam logic [1:0] FUNC_PLAIN  = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_IV_HIGH    = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_IV_LOW     = 3'd5;

   typedef logic [15:0][7:0] blk_type;
   typedef logic [31:0][7:0] key_type;

   typedef enum logic [1:0] {
      OP_INIT,
      OP_CIPHER,
      OP_PLAIN
   } op_type;

   typedef struct packed {
      logic       valid;
      op_type     op;
      logic [7:0] data;
   } head_type;

   typedef struct packed {
      logic    start;
      blk_type block;
   } aes_req_type;

   typedef struct packed {
      logic    done;
      blk_type block;
   } aes_rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] b);
      xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // round constant for key schedule step k (1..7)
   function automatic logic [7:0] rcon(input logic [2:0] k);
      rcon = (k == 3'd0) ? 8'h00 : 8'(8'h01 << (k - 3'd1));
   endfunction

   function automatic blk_type unpack128(input logic [63:0] hi, input logic [63:0] lo);
      blk_type b;
      for (int i = 0; i < 8; i++) begin
         b[i]     = hi[63-8*i -: 8];
         b[i + 8] = lo[63-8*i -: 8];
      end
      unpack128 = b;
   endfunction

endpackage
`default_nettype wire

[rtl/cfbd_req_if.sv]
`default_nettype none
interface cfbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_in;
   modport source (output valid, output func, output data_in, input ready);
   modport sink (input valid, input func, input data_in, output ready);
endinterface
`default_nettype wire

[rtl/cfbd_rsp_if.sv]
`default_nettype none
interface cfbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   modport source (output valid, output data_out, input ready);
   modport sink (input valid, input data_out, output ready);
endinterface
`default_nettype wire

[rtl/cfbd_front.sv]
`default_nettype none
module cfbd_front
   import cfbd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   cfbd_req_if.sink  req,
   output head_type  head,
   input  wire logic pop
);
   localparam int DEPTH = 4;
   localparam int PW = $clog2(DEPTH);

   op_type           op_q [DEPTH];
   logic [7:0]       data_q [DEPTH];
   logic [PW-1:0]    rd_ff, rd_in, wr_ff, wr_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             push;
   op_type           op_dec;

   assign req.ready = (cnt_ff != PW'(0) + (PW+1)'(DEPTH)) ? 1'b1 : 1'b0;

   // classify; unused selector is taken and dropped
   always_comb begin
      push   = 1'b0;
      op_dec = OP_CIPHER;
      case (req.func)
         FUNC_INIT:   begin op_dec = OP_INIT;   push = 1'b1; end
         FUNC_CIPHER: begin op_dec = OP_CIPHER; push = 1'b1; end
         FUNC_PLAIN:  begin op_dec = OP_PLAIN;  push = 1'b1; end
         default:     push = 1'b0;
      endcase
      push = push & req.valid & req.ready;
   end

   always_comb begin
      rd_in  = rd_ff + PW'(pop);
      wr_in  = wr_ff + PW'(push);
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         op_q[wr_ff]   <= op_dec;
         data_q[wr_ff] <= req.data_in;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.op    = op_q[rd_ff];
   assign head.data  = data_q[rd_ff];
endmodule
`default_nettype wire

[rtl/cfbd_aes.sv]
`default_nettype none
module cfbd_aes
   import cfbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire key_type     key,
   input  wire aes_req_type areq,
   output aes_rsp_type      arsp
);
   blk_type    s_ff, s_in, kp_ff, kp_in, kc_ff, kc_in, t, m, knew;
   logic [3:0] r_ff, r_in;
   logic       busy_ff, busy_in, done_ff, done_in;
   logic [7:0] a0, a1, a2, a3, all;
   logic [7:0] w [4];
   logic [3:0] nidx;

   always_comb begin
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            t[4*c+i] = SBOX[s_ff[4*((c+i)%4)+i]];
      m = t;
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
         m[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
         m[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
         m[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
      end
      // next round key, index r+1
      nidx = r_ff + 4'd1;
      if (!nidx[0]) begin
         w[0] = SBOX[kc_ff[13]] ^ rcon(nidx[3:1]);
         w[1] = SBOX[kc_ff[14]];
         w[2] = SBOX[kc_ff[15]];
         w[3] = SBOX[kc_ff[12]];
      end else begin
         for (int c = 0; c < 4; c++) w[c] = SBOX[kc_ff[12+c]];
      end
      for (int c = 0; c < 4; c++) knew[c] = kp_ff[c] ^ w[c];
      for (int j = 4; j < 16; j++) knew[j] = kp_ff[j] ^ knew[j-4];

      s_in    = s_ff;
      kp_in   = kp_ff;
      kc_in   = kc_ff;
      r_in    = r_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (areq.start) begin
         for (int i = 0; i < 16; i++) begin
            s_in[i]  = areq.block[i] ^ key[i];
            kp_in[i] = key[i];
            kc_in[i] = key[i+16];
         end
         r_in    = 4'd1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         s_in  = ((r_ff == 4'(ROUNDS)) ? t : m) ^ kc_ff;
         kp_in = kc_ff;
         kc_in = knew;
         r_in  = r_ff + 4'd1;
         if (r_ff == 4'(ROUNDS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         r_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         r_ff    <= r_in;
      end
      s_ff  <= s_in;
      kp_ff <= kp_in;
      kc_ff <= kc_in;
   end

   assign arsp.done  = done_ff;
   assign arsp.block = s_ff;
endmodule
`default_nettype wire

[rtl/cfbd_back.sv]
`default_nettype none
module cfbd_back
   import cfbd_pkg::*;
#(
   parameter int BLOCK_BYTES = CFBD_BLOCK_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire head_type    head,
   output logic             pop,
   input  wire blk_type     iv,
   output aes_req_type      areq,
   input  wire aes_rsp_type arsp,
   cfbd_rsp_if.source       rsp
);
   localparam int BLK = (BLOCK_BYTES < 8) ? 8 : ((BLOCK_BYTES > 16) ? 16 : BLOCK_BYTES);

   typedef enum logic [1:0] {ST_RUN, ST_WAIT_INIT, ST_WAIT_BLK} state_type;

   state_type  st_ff, st_in;
   blk_type    fb_ff, fb_in, pb_ff, pb_in, rs;
   logic [4:0] pos_ff, pos_in;
   logic       lp_ff, lp_in, ov_ff, ov_in;
   logic [7:0] od_ff, od_in;
   logic       out_free;

   assign out_free = !ov_ff || rsp.ready;

   // resync: feedback becomes the last BLK cipher bytes
   always_comb begin
      rs = fb_ff;
      for (int j = 0; j < BLK; j++) begin
         if (5'(j) < 5'(BLK) - pos_ff)
            rs[j] = pb_ff[4'(5'(j) + pos_ff)];
         else
            rs[j] = fb_ff[4'(5'(j) + pos_ff - 5'(BLK))];
      end
   end

   always_comb begin
      st_in      = st_ff;
      fb_in      = fb_ff;
      pb_in      = pb_ff;
      pos_in     = pos_ff;
      lp_in      = lp_ff;
      ov_in      = ov_ff && !rsp.ready;
      od_in      = od_ff;
      pop        = 1'b0;
      areq.start = 1'b0;
      areq.block = fb_ff;
      case (st_ff)
         ST_RUN: begin
            if (head.valid) begin
               case (head.op)
                  OP_INIT: begin
                     areq.start = 1'b1;
                     areq.block = iv;
                     st_in      = ST_WAIT_INIT;
                  end
                  OP_PLAIN: begin
                     if (out_free) begin
                        ov_in = 1'b1;
                        od_in = head.data;
                        lp_in = 1'b1;
                        pop   = 1'b1;
                     end
                  end
                  default: begin
                     if (lp_ff) begin
                        if (pos_ff < 5'(BLK)) fb_in = rs;
                        pos_in = 5'(BLK);
                        lp_in  = 1'b0;
                     end else if (pos_ff >= 5'(BLK)) begin
                        pb_in      = fb_ff;
                        areq.start = 1'b1;
                        st_in      = ST_WAIT_BLK;
                     end else if (out_free) begin
                        ov_in              = 1'b1;
                        od_in              = fb_ff[pos_ff[3:0]] ^ head.data;
                        fb_in[pos_ff[3:0]] = head.data;
                        pos_in             = pos_ff + 5'd1;
                        pop                = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_WAIT_INIT: begin
            if (arsp.done) begin
               fb_in  = arsp.block;
               pb_in  = arsp.block;
               pos_in = '0;
               lp_in  = 1'b0;
               pop    = 1'b1;
               st_in  = ST_RUN;
            end
         end
         ST_WAIT_BLK: begin
            if (arsp.done) begin
               fb_in  = arsp.block;
               pos_in = '0;
               st_in  = ST_RUN;
            end
         end
         default: st_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_RUN;
         fb_ff  <= '0;
         pb_ff  <= '0;
         pos_ff <= 5'(BLK);
         lp_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         fb_ff  <= fb_in;
         pb_ff  <= pb_in;
         pos_ff <= pos_in;
         lp_ff  <= lp_in;
         ov_ff  <= ov_in;
      end
      od_ff <= od_in;
   end

   assign rsp.valid    = ov_ff;
   assign rsp.data_out = od_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 5'(BLK)) else $error("byte position beyond block");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("pop from empty queue");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      arsp.done |-> (st_ff == ST_WAIT_INIT || st_ff == ST_WAIT_BLK))
      else $error("cipher result while not waiting");
   a_blk_pos: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_WAIT_BLK && arsp.done) |=> pos_ff == '0)
      else $error("position not restarted after block");
endmodule
`default_nettype wire

[rtl/cfb_byte_decrypt_with_resync.sv]
// channel   | dir | payload           | handshake
// req_chan  | in  | func[1:0], data_in | valid/ready
// rsp_chan  | out | data_out           | valid/ready
// csr_*     | in  | index, 64-bit data | write enable only
//
// cipher bytes leave at one per cycle within a block while the result side is ready; the byte
// that opens a block waits for the one-round-per-cycle aes-256 unit (key schedule on the fly)
// an init holds the back end while the aes unit runs and gives no transaction
// a cipher byte after plain bytes first passes through the resync shuffle, then opens a block
// synchronous active-high reset; no clearing pass
// a 4-deep queue lets the request side run on while the back end stalls
`default_nettype none
module cfb_byte_decrypt_with_resync
   import cfbd_pkg::*;
#(
   parameter int BLOCK_BYTES = CFBD_BLOCK_BYTES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   cfbd_req_if.sink                       req_chan,
   cfbd_rsp_if.source                     rsp_chan,
   input  wire logic                      csr_we,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]      csr_wdata
);
   logic [CSR_WIDTH-1:0] kw_ff [4];
   logic [CSR_WIDTH-1:0] ivh_ff, ivl_ff;
   key_type              key;
   blk_type              iv;
   head_type             head;
   logic                 pop;
   aes_req_type          areq;
   aes_rsp_type          arsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) kw_ff[i] <= '0;
         ivh_ff <= '0;
         ivl_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY_WORD_0: kw_ff[0] <= csr_wdata;
            REG_KEY_WORD_1: kw_ff[1] <= csr_wdata;
            REG_KEY_WORD_2: kw_ff[2] <= csr_wdata;
            REG_KEY_WORD_3: kw_ff[3] <= csr_wdata;
            REG_IV_HIGH:    ivh_ff   <= csr_wdata;
            REG_IV_LOW:     ivl_ff   <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // byte 0 is the most significant byte of each word
   always_comb begin
      for (int w = 0; w < 4; w++)
         for (int i = 0; i < 8; i++)
            key[8*w+i] = kw_ff[w][63-8*i -: 8];
      iv = unpack128(ivh_ff, ivl_ff);
   end

   // front: accept and classify into the queue
   cfbd_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .head  (head),
      .pop   (pop)
   );

   // shared iterative block cipher
   cfbd_aes u_aes (
      .clock (clock),
      .reset (reset),
      .key   (key),
      .areq  (areq),
      .arsp  (arsp)
   );

   // back: keystream, feedback and resync
   cfbd_back #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .iv    (iv),
      .areq  (areq),
      .arsp  (arsp),
      .rsp   (rsp_chan)
   );
endmodule
`default_nettype wire

[tb/cfb_byte_decrypt_with_resync_test.sv]
`default_nettype none
module cfb_byte_decrypt_with_resync_test;
   import cfbd_pkg::*;

   // selector value that the block must ignore
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // cycles the back end may still be busy once the last byte has left
   // (a queue full of init transactions)
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES = 200;

   typedef logic [7:0] state_bytes_type [16];

   // keystream predictor plus the queue of decrypted bytes still owed
   class decrypt_scoreboard;
      logic [63:0]     csr_value [6];
      state_bytes_type feedback;
      state_bytes_type previous;
      int unsigned     position;
      bit              after_plain;
      logic [7:0]      owed_bytes [$];
      int              errors;

      function new();
         foreach (csr_value[i]) csr_value[i] = '0;
         foreach (feedback[i]) begin
            feedback[i] = '0;
            previous[i] = '0;
         end
         position = 16;
         after_plain = 0;
         errors = 0;
      endfunction

      function void set_register(int idx, logic [63:0] val);
         csr_value[idx] = val;
      endfunction

      function logic [7:0] times_two(logic [7:0] b);
         return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
      endfunction

      function state_bytes_type aes256(state_bytes_type src);
         logic [7:0]      round_key [240];
         logic [7:0]      w [4];
         logic [7:0]      hold;
         logic [7:0]      a0, a1, a2, a3, all;
         state_bytes_type s, t;
         for (int i = 0; i < 32; i++)
            round_key[i] = csr_value[i / 8][63 - 8 * (i % 8) -: 8];
         for (int i = 8; i < 60; i++) begin
            for (int c = 0; c < 4; c++) w[c] = round_key[4 * (i - 1) + c];
            if (i % 8 == 0) begin
               hold = w[0];
               w[0] = SBOX[w[1]] ^ (8'h01 << (i / 8 - 1));
               w[1] = SBOX[w[2]];
               w[2] = SBOX[w[3]];
               w[3] = SBOX[hold];
            end else if (i % 8 == 4) begin
               for (int c = 0; c < 4; c++) w[c] = SBOX[w[c]];
            end
            for (int c = 0; c < 4; c++)
               round_key[4 * i + c] = round_key[4 * (i - 8) + c] ^ w[c];
         end
         for (int i = 0; i < 16; i++) s[i] = src[i] ^ round_key[i];
         for (int r = 1; r <= 14; r++) begin
            for (int c = 0; c < 4; c++)
               for (int i = 0; i < 4; i++)
                  t[4 * c + i] = SBOX[s[4 * ((c + i) % 4) + i]];
            if (r != 14) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = t[4 * c];
                  a1 = t[4 * c + 1];
                  a2 = t[4 * c + 2];
                  a3 = t[4 * c + 3];
                  all = a0 ^ a1 ^ a2 ^ a3;
                  t[4 * c]     = a0 ^ all ^ times_two(a0 ^ a1);
                  t[4 * c + 1] = a1 ^ all ^ times_two(a1 ^ a2);
                  t[4 * c + 2] = a2 ^ all ^ times_two(a2 ^ a3);
                  t[4 * c + 3] = a3 ^ all ^ times_two(a3 ^ a0);
               end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key[16 * r + i];
         end
         return s;
      endfunction

      function void note_request(logic [1:0] func, logic [7:0] data);
         state_bytes_type iv, shuffled;
         logic [7:0]      ks;
         case (func)
            FUNC_INIT: begin
               for (int i = 0; i < 8; i++) begin
                  iv[i]     = csr_value[REG_IV_HIGH][63 - 8 * i -: 8];
                  iv[i + 8] = csr_value[REG_IV_LOW][63 - 8 * i -: 8];
               end
               previous = aes256(iv);
               feedback = previous;
               position = 0;
               after_plain = 0;
            end
            FUNC_PLAIN: begin
               after_plain = 1;
               owed_bytes.push_back(data);
            end
            FUNC_CIPHER: begin
               if (after_plain) begin
                  if (position < 16) begin
                     for (int j = 0; j < 16; j++)
                        shuffled[j] = (j < 16 - position) ? previous[position + j]
                                                         : feedback[j - (16 - position)];
                     feedback = shuffled;
                  end
                  position = 16;
                  after_plain = 0;
               end
               if (position >= 16) begin
                  previous = feedback;
                  feedback = aes256(feedback);
                  position = 0;
               end
               ks = feedback[position];
               feedback[position] = data;
               position++;
               owed_bytes.push_back(ks ^ data);
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_byte(logic [7:0] got);
         logic [7:0] want;
         if (owed_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected data_out %02h", got));
         end else begin
            want = owed_bytes.pop_front();
            if (got !== want)
               report_mismatch($sformatf("data_out %02h, predicted %02h", got, want));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_ADDR_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   cfbd_req_if req_bus ();
   cfbd_rsp_if rsp_bus ();

   decrypt_scoreboard sb = new();

   // shared pacing controls
   bit idle_enabled = 1;
   bit hold_request = 0;

   cfb_byte_decrypt_with_resync uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // drive every input to a known value from time zero
   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 0;
      req_bus.func = FUNC_INIT;
      req_bus.data_in = '0;
      rsp_bus.ready = 0;
   end

   // one register write, then the enable drops again
   task write_csr(logic [CSR_ADDR_WIDTH-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      sb.set_register(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   // offer one transaction after a random gap and wait for it to be taken
   task send_item(logic [1:0] func, logic [7:0] data);
      int gap;
      gap = idle_enabled ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.func = func;
      req_bus.data_in = data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(func, data);
   endtask

   // block stays quiet until every owed byte is out, plus drain time
   task wait_idle();
      @(negedge clock);
      req_bus.valid = 0;
      while (sb.owed_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task load_settings(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                      logic [63:0] k3, logic [63:0] ivh, logic [63:0] ivl);
      write_csr(REG_KEY_WORD_0, k0);
      write_csr(REG_KEY_WORD_1, k1);
      write_csr(REG_KEY_WORD_2, k2);
      write_csr(REG_KEY_WORD_3, k3);
      write_csr(REG_IV_HIGH, ivh);
      write_csr(REG_IV_LOW, ivl);
   endtask

   // extremes of the byte, resync right after init and mid block, ignored selector
   task run_directed();
      send_item(FUNC_INIT, 8'hff);
      send_item(FUNC_PLAIN, 8'h00);
      send_item(FUNC_CIPHER, 8'h00);
      send_item(FUNC_CIPHER, 8'hff);
      repeat (15) send_item(FUNC_CIPHER, 8'($urandom));
      send_item(FUNC_PLAIN, 8'hff);
      send_item(FUNC_CIPHER, 8'h80);
      send_item(FUNC_UNUSED, 8'hff);
      send_item(FUNC_CIPHER, 8'h01);
   endtask

   // an init, then mostly cipher runs with plain bytes, inits and ignored selectors scattered in
   task run_random(int target, bit with_pressure);
      int sent;
      int pick;
      int run;
      bit pressure_done;
      sent = 0;
      pressure_done = 0;
      send_item(FUNC_INIT, 8'($urandom));
      while (sent < target) begin
         idle_enabled = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (with_pressure && !pressure_done && sent > target / 2) begin
            // back end stalls long while bytes keep coming, then full pause
            idle_enabled = 0;
            hold_request = 1;
            repeat (30) send_item(FUNC_CIPHER, 8'($urandom));
            sent += 30;
            @(negedge clock);
            req_bus.valid = 0;
            while (sb.owed_bytes.size() != 0) @(negedge clock);
            pressure_done = 1;
         end else if (pick < 6) begin
            send_item(FUNC_INIT, 8'($urandom));
            sent++;
         end else if (pick < 20) begin
            run = $urandom_range(1, 3);
            repeat (run) send_item(FUNC_PLAIN, 8'($urandom));
            sent += run;
         end else if (pick < 24) begin
            send_item(FUNC_UNUSED, 8'($urandom));
         end else begin
            run = $urandom_range(1, 20);
            repeat (run) send_item(FUNC_CIPHER, 8'($urandom));
            sent += run;
         end
      end
      idle_enabled = 1;
   endtask

   // result side: random stalls, and one long hold-off on request
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp_bus.ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end
         stall = idle_enabled ? $urandom_range(0, 9) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         sb.check_byte(rsp_bus.data_out);
      end
   end

   // main sequence
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // cipher bytes before any init use the zero feedback block
      send_item(FUNC_CIPHER, 8'h00);
      send_item(FUNC_CIPHER, 8'hff);
      send_item(FUNC_CIPHER, 8'h3c);
      wait_idle();

      load_settings('0, '0, '0, '0, '0, '0);
      run_directed();
      run_random(100, 0);
      wait_idle();

      load_settings('1, '1, '1, '1, '1, '1);
      run_random(110, 1);
      wait_idle();

      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      run_random(120, 0);
      wait_idle();

      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      run_random(120, 0);
      wait_idle();

      if (sb.owed_bytes.size() != 0)
         sb.report_mismatch($sformatf("%0d bytes never arrived", sb.owed_bytes.size()));
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
rtl/cfbd_pkg.sv
rtl/cfbd_req_if.sv
rtl/cfbd_rsp_if.sv
rtl/cfbd_front.sv
rtl/cfbd_aes.sv
rtl/cfbd_back.sv
rtl/cfb_byte_decrypt_with_resync.sv
tb/cfb_byte_decrypt_with_resync_test.sv
